>>> hw/rtl/sff_pkg.sv
// Shared types and constants for the streaming FIR filter.
`timescale 1ns / 1ps
`default_nettype none

package sff_pkg;

  localparam int TAPS       = 8;
  localparam int NCOEF      = 8;
  localparam int DATA_W     = 16;
  localparam int FRAC_W     = 15;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ACC_W      = PROD_W + $clog2(TAPS) + 1;
  localparam int REG_IDX_W  = $clog2(NCOEF);
  localparam int ADDR_W     = REG_IDX_W + 2;
  localparam int APB_DATA_W = 32;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef sample_t coef_array_t [NCOEF];
  typedef prod_t   prod_array_t [TAPS];

  typedef struct packed {
    logic                  sel;
    logic                  enable;
    logic                  write;
    logic [ADDR_W-1:0]     addr;
    logic [APB_DATA_W-1:0] wdata;
  } apb_req_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam acc_t    ROUND_BIAS = acc_t'(1) <<< (FRAC_W - 1);

endpackage

`default_nettype wire

>>> hw/rtl/sff_apb_regs.sv
// APB coefficient register file for the streaming FIR filter.
`timescale 1ns / 1ps
`default_nettype none

module sff_apb_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  sff_pkg::apb_req_t              apb,
  output logic [sff_pkg::APB_DATA_W-1:0] prdata,
  output sff_pkg::coef_array_t           coef
);
  import sff_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 write_en;

  assign idx      = apb.addr[ADDR_W-1:2];
  assign write_en = apb.sel && apb.enable && apb.write && (int'(idx) < NCOEF);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NCOEF; k++) begin
        coef[k] <= '0;
      end
    end else if (write_en) begin
      coef[idx] <= apb.wdata[DATA_W-1:0];
    end
  end

  always_comb begin
    prdata = {{(APB_DATA_W-DATA_W){coef[idx][DATA_W-1]}}, coef[idx]};
  end

endmodule

`default_nettype wire

>>> hw/rtl/sff_sum_sat.sv
// Product summation, round-half-up and 16-bit saturation for the FIR filter.
`timescale 1ns / 1ps
`default_nettype none

module sff_sum_sat (
  input  sff_pkg::prod_array_t prod,
  output sff_pkg::sample_t     result,
  output logic                 clip
);
  import sff_pkg::*;

  acc_t sum;
  acc_t rounded;
  acc_t scaled;

  always_comb begin
    sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum = sum + acc_t'(prod[k]);
    end
    rounded = sum + ROUND_BIAS;
    scaled  = rounded >>> FRAC_W;
    if (scaled > acc_t'(SAMPLE_MAX)) begin
      result = SAMPLE_MAX;
      clip   = 1'b1;
    end else if (scaled < acc_t'(SAMPLE_MIN)) begin
      result = SAMPLE_MIN;
      clip   = 1'b1;
    end else begin
      result = scaled[DATA_W-1:0];
      clip   = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/streaming_fir_filter_core.sv
// Top level of the streaming direct-form FIR filter.
//
// Input samples arrive on the sample_in channel (in_valid/in_ready) and one
// filtered sample leaves on the output channel (out_valid/out_ready) for each
// input transaction, together with a clipped flag that marks saturation.
// The eight Q1.15 coefficients are written through the APB port, at byte
// address 4*k for coef_k; pready is always high and reads return the value.
// Coefficients should only be changed while no transaction is in flight.
// An input transaction forms the eight products into a product register;
// from there they are summed, rounded and saturated into the output register.
// Throughput is one sample per cycle while the receiver does not stall, set
// by the single product stage and the output register.
// When the receiver stalls, the output holds and the product stage fills;
// in_ready then falls until the output is taken, so no sample is lost.
// A synchronous reset clears the sample history, the coefficients and both
// pipeline valid flags.

`timescale 1ns / 1ps
`default_nettype none

module streaming_fir_filter_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sff_pkg::ADDR_W-1:0]     paddr,
  input  logic [sff_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sff_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sff_pkg::sample_t               sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sff_pkg::sample_t               sample_out,
  output logic                           clipped
);
  import sff_pkg::*;

  apb_req_t    apb;
  coef_array_t coef;
  sample_t     tap [TAPS];
  prod_array_t prod;
  logic        s1_valid;
  logic        s1_ready;
  logic        s2_ready;
  logic        in_fire;
  sample_t     sat_sample;
  logic        sat_clip;

  assign apb    = '{sel: psel, enable: penable, write: pwrite, addr: paddr, wdata: pwdata};
  assign pready = 1'b1;

  sff_apb_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .apb    (apb),
    .prdata (prdata),
    .coef   (coef)
  );

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;
  assign in_fire  = in_valid && in_ready;

  assign tap[0] = sample_in;

  if (TAPS > 1) begin : g_hist
    sample_t hist [TAPS-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        for (int k = 0; k < TAPS - 1; k++) begin
          hist[k] <= '0;
        end
      end else if (in_fire) begin
        hist[0] <= sample_in;
        for (int k = 1; k < TAPS - 1; k++) begin
          hist[k] <= hist[k-1];
        end
      end
    end

    for (genvar k = 1; k < TAPS; k++) begin : g_tap
      assign tap[k] = hist[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < TAPS; k++) begin
        prod[k] <= prod_t'(tap[k]) * prod_t'(coef[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  sff_sum_sat u_sum_sat (
    .prod   (prod),
    .result (sat_sample),
    .clip   (sat_clip)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      sample_out <= sat_sample;
      clipped    <= sat_clip;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sff_checker.sv
// Port-level assertions for the streaming FIR filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sff_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input sff_pkg::sample_t sample_out,
  input logic             clipped
);
  import sff_pkg::*;

  // A reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // An accepted sample always leaves a result pending after the product and output registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> ##2 out_valid)
    else $error("result missing two cycles after input transaction");

  // A stalled result holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample_out) && $stable(clipped)))
    else $error("stalled result changed");

  // A clipped result sits at one of the two range limits.
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |-> (sample_out == SAMPLE_MAX || sample_out == SAMPLE_MIN))
    else $error("clipped result not at a range limit");

endmodule

bind streaming_fir_filter_core sff_checker u_sff_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out),
  .clipped    (clipped)
);

`default_nettype wire

>>> tb/tb_streaming_fir_filter_core.sv
// Self-checking testbench for the streaming FIR filter core with a coefficient scoreboard.
`timescale 1ns / 1ps

module tb_streaming_fir_filter_core;
  import sff_pkg::*;

  typedef struct {
    sample_t value;
    logic    clip;
  } fir_out_t;

  typedef enum int {
    COEF_RANDOM,
    COEF_SMALL,
    COEF_MAX,
    COEF_MIN,
    COEF_SPARSE,
    COEF_MIXED
  } coef_style_t;

  localparam int      ITEM_GOAL   = 1600;
  localparam int      N_STYLES    = 6;
  localparam int      REG_STRIDE  = 4;
  localparam int      IDLE_PCT    = 15;
  localparam int      SETTLE      = 4;
  localparam sample_t COEF_HALF   = 16'sd16384;

  class fir_output_tracker;
    sample_t  coef [NCOEF];
    sample_t  hist [NCOEF];
    fir_out_t pending_outputs [$];
    int       n_samples;
    int       n_outputs;
    int       n_clipped;
    int       n_errors;

    function new();
      for (int k = 0; k < NCOEF; k++) begin
        coef[k] = '0;
        hist[k] = '0;
      end
      n_samples = 0;
      n_outputs = 0;
      n_clipped = 0;
      n_errors  = 0;
    endfunction

    function void set_coef(int idx, sample_t val);
      coef[idx] = val;
    endfunction

    function void log_failure(string msg);
      n_errors++;
      if (n_errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void take_sample(sample_t x);
      longint   acc;
      longint   q;
      fir_out_t r;
      acc = longint'(coef[0]) * longint'(x);
      for (int k = 1; k < TAPS; k++)
        acc += longint'(coef[k]) * longint'(hist[k - 1]);
      q = (acc + longint'(ROUND_BIAS)) >>> FRAC_W;
      r.clip = 1'b0;
      if (q > longint'(SAMPLE_MAX)) begin
        q = longint'(SAMPLE_MAX);
        r.clip = 1'b1;
      end else if (q < longint'(SAMPLE_MIN)) begin
        q = longint'(SAMPLE_MIN);
        r.clip = 1'b1;
      end
      r.value = sample_t'(q);
      if (r.clip) n_clipped++;
      for (int k = TAPS - 2; k > 0; k--)
        hist[k] = hist[k - 1];
      if (TAPS > 1) hist[0] = x;
      pending_outputs.push_back(r);
      n_samples++;
    endfunction

    function void match_output(sample_t y, logic c);
      fir_out_t want;
      n_outputs++;
      if (pending_outputs.size() == 0) begin
        log_failure($sformatf("output transaction %0d with none expected: %0d clipped=%0b",
                              n_outputs, y, c));
      end else begin
        want = pending_outputs.pop_front();
        if (y !== want.value || c !== want.clip)
          log_failure($sformatf(
              "output transaction %0d: expected %0d clipped=%0b, got %0d clipped=%0b",
              n_outputs, want.value, want.clip, y, c));
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_ready;
  sample_t               sample_in;
  logic                  out_valid;
  logic                  out_ready;
  sample_t               sample_out;
  logic                  clipped;

  fir_output_tracker tracker;
  sample_t           next_coefs [NCOEF];
  logic              calm;
  int                coef_sets;

  streaming_fir_filter_core dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .clipped    (clipped)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.match_output(sample_out, clipped);
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic void pick_coefs(coef_style_t style);
    for (int k = 0; k < NCOEF; k++) begin
      case (style)
        COEF_RANDOM: next_coefs[k] = sample_t'($urandom());
        COEF_SMALL:  next_coefs[k] = sample_t'($urandom_range(8191)) - 16'sd4096;
        COEF_MAX:    next_coefs[k] = SAMPLE_MAX;
        COEF_MIN:    next_coefs[k] = SAMPLE_MIN;
        COEF_SPARSE: next_coefs[k] = ($urandom_range(3) == 0) ? sample_t'($urandom()) : '0;
        default: begin
          case ($urandom_range(3))
            0:       next_coefs[k] = SAMPLE_MAX;
            1:       next_coefs[k] = SAMPLE_MIN;
            2:       next_coefs[k] = '0;
            default: next_coefs[k] = sample_t'($urandom());
          endcase
        end
      endcase
    end
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return sample_t'($urandom_range(511)) - 16'sd256;
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic send_sample(input sample_t x);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (!in_ready);
    tracker.take_sample(x);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_coefs();
    wait_drained();
    for (int k = 0; k < NCOEF; k++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(REG_STRIDE * k);
      pwdata  <= {16'($urandom()), next_coefs[k]};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      tracker.set_coef(k, next_coefs[k]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    coef_sets++;
  endtask

  initial begin
    #2_000_000;
    $display("tb_streaming_fir_filter_core: errors");
    $finish;
  end

  initial begin
    int phase;
    clk       = 1'b0;
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    sample_in = '0;
    calm      = 1'b0;
    coef_sets = 0;
    tracker   = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With all coefficients at reset, the extremes must filter to zero.
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);

    // A half weight on one tap puts odd samples exactly on a rounding tie.
    foreach (next_coefs[k]) next_coefs[k] = '0;
    next_coefs[0] = COEF_HALF;
    load_coefs();
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd3);
    send_sample(-16'sd3);

    // The most negative weight times the most negative sample overflows one tap.
    next_coefs[0] = SAMPLE_MIN;
    load_coefs();
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);

    pick_coefs(COEF_MAX);
    load_coefs();
    repeat (8) send_sample(SAMPLE_MAX);
    repeat (8) send_sample(SAMPLE_MIN);

    phase = 0;
    while (tracker.n_samples < ITEM_GOAL) begin
      if (phase == 0) pick_coefs(COEF_MIN);
      else pick_coefs(coef_style_t'($urandom_range(N_STYLES - 1)));
      load_coefs();
      calm = (phase == 3);
      repeat ($urandom_range(170, 60)) send_sample(pick_sample());
      phase++;
    end
    calm = 1'b0;
    wait_drained();

    $display("Covered %0d samples over %0d coefficient sets; %0d outputs saturated.",
             tracker.n_samples, coef_sets, tracker.n_clipped);
    $display("Checked %0d output transactions, %0d mismatches.",
             tracker.n_outputs, tracker.n_errors);
    if (tracker.n_errors == 0 && tracker.pending_outputs.size() == 0) begin
      $display("tb_streaming_fir_filter_core: clean");
    end else begin
      $display("tb_streaming_fir_filter_core: errors");
    end
    $finish;
  end

endmodule
